>>> rtl/pid_channel_nonlinear_gain_top_macros.svh
// Assertion macros for the nonlinear-gain PID channel.
// Each macro expands to one labelled concurrent assertion clocked on clk and
// disabled while arst_n is low; both names must be visible where it is used.
`ifndef PID_CHANNEL_NONLINEAR_GAIN_TOP_MACROS_SVH
`define PID_CHANNEL_NONLINEAR_GAIN_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PIDNG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PIDNG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/pidng_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths, constants and the saturation helper of the PID channel.
// No dependencies; every other file of the block but the assertion macros header imports it.
package pidng_pkg;

	localparam int DATA_W    = 32;
	localparam int STEP_W    = 31;
	localparam int CFG_IDX_W = 3;

	// Shift-add multiplier operand and product widths
	localparam int MA_W = DATA_W + 2;
	localparam int MB_W = DATA_W + 1;
	localparam int P_W  = MA_W + MB_W;

	// Ratio divider operand width
	localparam int DIV_W = DATA_W + 1;

	localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// Register reset values (Q16.16)
	localparam logic                     RST_MODE      = 1'b0;
	localparam logic signed [DATA_W-1:0] RST_UPPER     = 32'sd196608;
	localparam logic signed [DATA_W-1:0] RST_LOWER     = -32'sd196608;
	localparam logic signed [DATA_W-1:0] RST_GAIN_N    = 32'sd32768;
	localparam logic signed [DATA_W-1:0] RST_GAIN_V    = 32'sd32768;
	localparam logic signed [DATA_W-1:0] RST_GAIN_P    = 32'sd32768;
	localparam logic [STEP_W-1:0]        RST_STEP_TIME = 31'd655;
	localparam logic [STEP_W-1:0]        RST_STEP_RATE = 31'd6553600;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE,
		CFG_UPPER,
		CFG_LOWER,
		CFG_GAIN_N,
		CFG_GAIN_V,
		CFG_GAIN_P,
		CFG_STEP_TIME,
		CFG_STEP_RATE
	} cfg_idx_t;

	typedef struct packed {
		logic                   start;
		logic signed [MA_W-1:0] a;
		logic signed [MB_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic                  done;
		logic signed [P_W-1:0] p;
	} mul_rsp_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	// Clip a wide signed value to the signed data range
	function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [P_W-1:0] x);
		if (x > P_W'(DATA_MAX)) begin
			return DATA_MAX;
		end
		if (x < P_W'(DATA_MIN)) begin
			return DATA_MIN;
		end
		return DATA_W'(x);
	endfunction

endpackage

>>> rtl/pidng_if.sv
`timescale 1ns / 1ps
// Valid/ready channels of the PID channel: the sample item and the result item.
// Depends on pidng_pkg for the field widths.
interface pidng_sample_if import pidng_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     enable;
	logic signed [DATA_W-1:0] error;
	logic signed [DATA_W-1:0] velocity;

	modport source (output valid, enable, error, velocity, input ready);
	modport sink   (input valid, enable, error, velocity, output ready);
endinterface

interface pidng_result_if import pidng_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] drive;

	modport source (output valid, drive, input ready);
	modport sink   (input valid, drive, output ready);
endinterface

>>> rtl/pidng_mul.sv
`timescale 1ns / 1ps
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
// Depends on pidng_pkg for the request and response structs.
module pidng_mul import pidng_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	localparam int CNT_W = $clog2(MB_W);

	logic                   busy_q;
	logic                   done_q;
	logic [CNT_W-1:0]       cnt_q;
	logic signed [MA_W-1:0] a_q;
	logic signed [MA_W:0]   hi_q;
	logic [MB_W-1:0]        lo_q;

	logic                   last;
	logic signed [MA_W:0]   a_ext;
	logic signed [MA_W:0]   addend;
	logic signed [MA_W:0]   sum;
	logic [MA_W+MB_W:0]     prod_full;

	assign last  = (cnt_q == CNT_W'(MB_W - 1));
	assign a_ext = (MA_W + 1)'(a_q);

	// Top multiplier bit carries negative weight: subtract on the last step
	always_comb begin
		if (!lo_q[0]) begin
			addend = '0;
		end else if (last) begin
			addend = -a_ext;
		end else begin
			addend = a_ext;
		end
		sum = hi_q + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			a_q    <= '0;
			hi_q   <= '0;
			lo_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				a_q    <= req.a;
				hi_q   <= '0;
				lo_q   <= req.b;
			end else if (busy_q) begin
				hi_q  <= sum >>> 1;
				lo_q  <= {sum[0], lo_q[MB_W-1:1]};
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign prod_full = {hi_q, lo_q};
	assign rsp.done  = done_q;
	assign rsp.p     = prod_full[P_W-1:0];

endmodule

>>> rtl/pidng_div.sv
`timescale 1ns / 1ps
// Restoring divider for the shaping ratio, one quotient bit per cycle.
// Depends on pidng_pkg; expects dividend below divisor, so FRAC_BITS bits suffice.
module pidng_div import pidng_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  div_req_t             req,
	output logic                 done,
	output logic [FRAC_BITS-1:0] quot
);

	localparam int CNT_W = $clog2(FRAC_BITS + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     den_q;
	logic [FRAC_BITS-1:0] quot_q;

	logic [DIV_W:0]       trial;
	logic                 fits;

	assign trial = {rem_q, 1'b0};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			quot_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(FRAC_BITS);
				rem_q  <= req.dividend;
				den_q  <= req.divisor;
			end else if (busy_q) begin
				rem_q  <= fits ? DIV_W'(trial - {1'b0, den_q}) : trial[DIV_W-1:0];
				quot_q <= {quot_q[FRAC_BITS-2:0], fits};
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

>>> rtl/pid_channel_nonlinear_gain_top.sv
`timescale 1ns / 1ps
// Top level of the nonlinear-gain PID channel: register file, sequencer, result register.
// Depends on pidng_pkg, pidng_if, pidng_mul and pidng_div.
//
// One PID channel evaluated once per sample item, values in fixed point with
// FRAC_BITS fraction bits, signed but for the unsigned step factors and ratio.
// Each accepted sample yields exactly one drive item. With enable low the integral
// and previous error clear and the drive is zero. Otherwise every product goes
// through one shared bit-serial multiplier, which sets the rate: a product takes
// an issue, a load, 33 shift-add steps and a capture. Mode 1 needs four products.
// Mode 0 needs five when the error magnitude is at or above the upper bound (or the
// window is empty), six when it lies below the lower bound, and seven when it lies
// inside the window, the latter plus a restoring division for the ratio. One sample
// is in work at a time: sample.ready is high only while the sequencer is idle. A
// finished drive waits in an output register, so the next sample is taken while the
// previous drive is still stalled. Write configuration only while the block is idle.
module pid_channel_nonlinear_gain_top
	import pidng_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	pidng_sample_if.sink          sample,
	pidng_result_if.source        result,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0]     cfg_wdata
);

	localparam int SUM_W = MA_W + 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SHAPE,
		ST_MUL_SMALL,
		ST_MUL_K,
		ST_DIV_R,
		ST_MUL_UK,
		ST_FIX_Y,
		ST_MUL_T,
		ST_CLAMP,
		ST_MUL_DR,
		ST_MUL_DV,
		ST_MUL_SN,
		ST_SUM_Q,
		ST_MUL_Q,
		ST_DONE
	} state_t;

	// Configuration registers
	logic                     mode_q;
	logic signed [DATA_W-1:0] upper_q;
	logic signed [DATA_W-1:0] lower_q;
	logic signed [DATA_W-1:0] gain_n_q;
	logic signed [DATA_W-1:0] gain_v_q;
	logic signed [DATA_W-1:0] gain_p_q;
	logic [STEP_W-1:0]        step_time_q;
	logic [STEP_W-1:0]        step_rate_q;

	// Sequencer and working registers
	state_t                   state_q;
	logic                     issued_q;
	mul_req_t                 mul_req_q;
	div_req_t                 div_req_q;
	logic signed [DATA_W-1:0] e_q;
	logic signed [DATA_W-1:0] v_q;
	logic signed [DATA_W-1:0] x_q;
	logic signed [DATA_W-1:0] k_q;
	logic [FRAC_BITS-1:0]     r_q;
	logic signed [MA_W-1:0]   t_q;
	logic signed [P_W-1:0]    sraw_q;
	logic signed [DATA_W-1:0] diff_q;
	logic signed [DATA_W-1:0] t1_q;
	logic signed [DATA_W-1:0] dterm_q;
	logic signed [DATA_W-1:0] pt_q;
	logic signed [DATA_W-1:0] q_q;
	logic signed [DATA_W-1:0] res_q;
	logic signed [DATA_W-1:0] integral_q;
	logic signed [DATA_W-1:0] prev_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] drive_q;

	// Shared arithmetic units
	mul_rsp_t                 mul_rsp;
	logic                     div_done;
	logic [FRAC_BITS-1:0]     div_quot;

	logic                     mul_state;
	logic signed [MA_W-1:0]   mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [P_W-1:0]    mp_sh;
	logic signed [DATA_W-1:0] mp_sat;

	logic signed [MA_W-1:0]   e_x;
	logic signed [MA_W-1:0]   abs_x;
	logic signed [MA_W-1:0]   u_x;
	logic signed [MA_W-1:0]   l_x;
	logic signed [MA_W-1:0]   span_x;
	logic signed [MA_W-1:0]   d_x;
	logic signed [SUM_W-1:0]  y_sum;
	logic signed [DATA_W-1:0] y_pos;
	logic signed [DATA_W-1:0] y_val;
	logic signed [DATA_W-1:0] s_clamp;
	logic signed [MA_W-1:0]   q_sum;

	pidng_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req_q),
		.rsp    (mul_rsp)
	);

	pidng_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Register writes; an unknown index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= RST_MODE;
			upper_q     <= RST_UPPER;
			lower_q     <= RST_LOWER;
			gain_n_q    <= RST_GAIN_N;
			gain_v_q    <= RST_GAIN_V;
			gain_p_q    <= RST_GAIN_P;
			step_time_q <= RST_STEP_TIME;
			step_rate_q <= RST_STEP_RATE;
		end else if (cfg_wen) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MODE:      mode_q      <= cfg_wdata[0];
				CFG_UPPER:     upper_q     <= cfg_wdata;
				CFG_LOWER:     lower_q     <= cfg_wdata;
				CFG_GAIN_N:    gain_n_q    <= cfg_wdata;
				CFG_GAIN_V:    gain_v_q    <= cfg_wdata;
				CFG_GAIN_P:    gain_p_q    <= cfg_wdata;
				CFG_STEP_TIME: step_time_q <= cfg_wdata[STEP_W-1:0];
				CFG_STEP_RATE: step_rate_q <= cfg_wdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// Product back from the multiplier: floor shift by the fraction, then clip
	assign mp_sh  = mul_rsp.p >>> FRAC_BITS;
	assign mp_sat = sat_data(mp_sh);

	// Shaping window tests on the true magnitude of the error
	assign e_x    = MA_W'(e_q);
	assign abs_x  = e_q[DATA_W-1] ? -e_x : e_x;
	assign u_x    = MA_W'(upper_q);
	assign l_x    = MA_W'(lower_q);
	assign span_x = u_x - l_x;
	assign d_x    = abs_x - l_x;

	// Middle segment: k + (U-k)*r, mirrored for a negative error
	always_comb begin
		y_sum = SUM_W'(k_q) + SUM_W'(t_q);
		y_pos = sat_data(P_W'(y_sum));
		if (!e_q[DATA_W-1]) begin
			y_val = y_pos;
		end else if (y_pos == DATA_MIN) begin
			y_val = DATA_MAX;
		end else begin
			y_val = -y_pos;
		end
	end

	// Integrator clamp: the upper bound wins when the bounds are crossed
	always_comb begin
		if (sraw_q > P_W'(upper_q)) begin
			s_clamp = upper_q;
		end else if (sraw_q < P_W'(lower_q)) begin
			s_clamp = lower_q;
		end else begin
			s_clamp = DATA_W'(sraw_q);
		end
	end

	// Mode 1 subtracts the velocity term
	assign q_sum = e_x + MA_W'(pt_q) + (mode_q ? -MA_W'(dterm_q) : MA_W'(dterm_q));

	// Operands for each product step
	always_comb begin
		mul_state = state_q inside {ST_MUL_SMALL, ST_MUL_K, ST_MUL_UK, ST_MUL_T,
			ST_MUL_DR, ST_MUL_DV, ST_MUL_SN, ST_MUL_Q};
		case (state_q)
			ST_MUL_SMALL: begin
				mul_a = MA_W'(gain_n_q);
				mul_b = MB_W'(e_q);
			end
			ST_MUL_K: begin
				mul_a = MA_W'(gain_n_q);
				mul_b = MB_W'(lower_q);
			end
			ST_MUL_UK: begin
				mul_a = u_x - MA_W'(k_q);
				mul_b = MB_W'(r_q);
			end
			ST_MUL_T: begin
				mul_a = MA_W'(x_q);
				mul_b = MB_W'(step_time_q);
			end
			ST_MUL_DR: begin
				mul_a = MA_W'(diff_q);
				mul_b = MB_W'(step_rate_q);
			end
			ST_MUL_DV: begin
				mul_a = mode_q ? MA_W'(v_q) : MA_W'(t1_q);
				mul_b = MB_W'(gain_v_q);
			end
			ST_MUL_SN: begin
				mul_a = MA_W'(integral_q);
				mul_b = MB_W'(gain_n_q);
			end
			ST_MUL_Q: begin
				mul_a = MA_W'(q_q);
				mul_b = MB_W'(gain_p_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issued_q    <= 1'b0;
			mul_req_q   <= '0;
			div_req_q   <= '0;
			e_q         <= '0;
			v_q         <= '0;
			x_q         <= '0;
			k_q         <= '0;
			r_q         <= '0;
			t_q         <= '0;
			sraw_q      <= '0;
			diff_q      <= '0;
			t1_q        <= '0;
			dterm_q     <= '0;
			pt_q        <= '0;
			q_q         <= '0;
			res_q       <= '0;
			integral_q  <= '0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
			drive_q     <= '0;
		end else begin
			// Launch the shared unit once on entry to a product or ratio step
			if (mul_state && !issued_q) begin
				mul_req_q <= '{start: 1'b1, a: mul_a, b: mul_b};
			end else begin
				mul_req_q.start <= 1'b0;
			end
			if (state_q == ST_DIV_R && !issued_q) begin
				div_req_q <= '{start: 1'b1, dividend: DIV_W'(d_x), divisor: DIV_W'(span_x)};
			end else begin
				div_req_q.start <= 1'b0;
			end
			if (mul_rsp.done || div_done) begin
				issued_q <= 1'b0;
			end else if ((mul_state || state_q == ST_DIV_R) && !issued_q) begin
				issued_q <= 1'b1;
			end

			// Load a finished drive when the output register is free; drop a taken one
			if (state_q == ST_DONE && (!out_valid_q || result.ready)) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (sample.valid) begin
						e_q <= sample.error;
						v_q <= sample.velocity;
						if (!sample.enable) begin
							integral_q <= '0;
							prev_q     <= '0;
							res_q      <= '0;
							state_q    <= ST_DONE;
						end else if (mode_q) begin
							x_q     <= sample.error;
							state_q <= ST_MUL_T;
						end else begin
							state_q <= ST_SHAPE;
						end
					end
				end
				ST_SHAPE: begin
					if (abs_x >= u_x) begin
						x_q     <= e_q;
						state_q <= ST_MUL_T;
					end else if (abs_x < l_x) begin
						state_q <= ST_MUL_SMALL;
					end else if (span_x[MA_W-1] || span_x == '0) begin
						x_q     <= e_q;
						state_q <= ST_MUL_T;
					end else begin
						state_q <= ST_MUL_K;
					end
				end
				ST_MUL_SMALL: begin
					if (mul_rsp.done) begin
						x_q     <= mp_sat;
						state_q <= ST_MUL_T;
					end
				end
				ST_MUL_K: begin
					if (mul_rsp.done) begin
						k_q     <= mp_sat;
						state_q <= ST_DIV_R;
					end
				end
				ST_DIV_R: begin
					if (div_done) begin
						r_q     <= div_quot;
						state_q <= ST_MUL_UK;
					end
				end
				ST_MUL_UK: begin
					if (mul_rsp.done) begin
						t_q     <= MA_W'(mp_sh);
						state_q <= ST_FIX_Y;
					end
				end
				ST_FIX_Y: begin
					x_q     <= y_val;
					state_q <= ST_MUL_T;
				end
				ST_MUL_T: begin
					if (mul_rsp.done) begin
						sraw_q  <= mp_sh + P_W'(integral_q);
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					integral_q <= s_clamp;
					if (mode_q) begin
						state_q <= ST_MUL_DV;
					end else begin
						diff_q  <= sat_data(P_W'(e_x - MA_W'(prev_q)));
						prev_q  <= e_q;
						state_q <= ST_MUL_DR;
					end
				end
				ST_MUL_DR: begin
					if (mul_rsp.done) begin
						t1_q    <= mp_sat;
						state_q <= ST_MUL_DV;
					end
				end
				ST_MUL_DV: begin
					if (mul_rsp.done) begin
						dterm_q <= mp_sat;
						state_q <= ST_MUL_SN;
					end
				end
				ST_MUL_SN: begin
					if (mul_rsp.done) begin
						pt_q    <= mp_sat;
						state_q <= ST_SUM_Q;
					end
				end
				ST_SUM_Q: begin
					q_q     <= sat_data(P_W'(q_sum));
					state_q <= ST_MUL_Q;
				end
				ST_MUL_Q: begin
					if (mul_rsp.done) begin
						res_q   <= mp_sat;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// Hold until the output register is free
					if (!out_valid_q || result.ready) begin
						drive_q <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign sample.ready = (state_q == ST_IDLE);
	assign result.valid = out_valid_q;
	assign result.drive = drive_q;

endmodule

>>> rtl/pidng_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the PID channel, bound to the top level below.
// Depends on pidng_pkg and pid_channel_nonlinear_gain_top_macros.svh.
`include "pid_channel_nonlinear_gain_top_macros.svh"

module pidng_checker import pidng_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              sample_valid,
	input logic              sample_ready,
	input logic              result_valid,
	input logic              result_ready,
	input logic [DATA_W-1:0] result_drive
);

	// One item in work at a time: the channel closes after a take
	`PIDNG_ASSERT_NEXT(a_busy_after_take, sample_valid && sample_ready, !sample_ready, "sample taken while busy")

	// A result only appears at the end of work, never from the idle state
	`PIDNG_ASSERT_NOW(a_result_from_work, $rose(result_valid), $past(!sample_ready), "result without work")

	// A stalled result stays put
	`PIDNG_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid && $stable(result_drive), "stalled result changed")

endmodule

bind pid_channel_nonlinear_gain_top pidng_checker u_pidng_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample.valid),
	.sample_ready (sample.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_drive (result.drive)
);
